// ===== src/day_count_to_calendar_date_defines.svh =====
// Assertion macros shared by the calendar date converter RTL.
// Define NO_ASSERTIONS to compile every check away; nothing else is required.
`ifndef DAY_COUNT_TO_CALENDAR_DATE_DEFINES_SVH
`define DAY_COUNT_TO_CALENDAR_DATE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checks a condition at every clock edge outside reset.
`define DCD_ASSERT_HOLDS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("dcd assertion failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define DCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dcd assertion failed");
`else
`define DCD_ASSERT_HOLDS(label, clk, rst, cond)
`define DCD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/dcd_pkg.sv =====
// Constants and the month start table of the calendar date converter.
// Depends on nothing; imported by day_count_to_calendar_date.
package dcd_pkg;

   localparam int unsigned DaysOffset     = 731;   // 1976-01-01 to 1978-01-01
   localparam int unsigned BaseYear       = 1976;
   localparam int unsigned DaysPerYear    = 365;
   localparam int unsigned DaysPerLeap    = 366;
   localparam int unsigned DaysPerQuad    = 3 * DaysPerYear + DaysPerLeap;
   localparam int unsigned LastDay2099    = 44559;
   localparam int unsigned MinutesPerHour = 60;
   localparam int unsigned TicksPerSecond = 50;
   localparam int unsigned SecondsPerMin  = 60;
   localparam int unsigned MonthCount     = 12;

   // Reciprocals that round down, so each quotient estimate is exact or one low.
   localparam int unsigned QuadRecip  = 2870;
   localparam int unsigned QuadShift  = 22;
   localparam int unsigned HourRecip  = 273;
   localparam int unsigned HourShift  = 14;
   localparam int unsigned SecRecip   = 1310;
   localparam int unsigned SecShift   = 16;

   // First day of a month, counted from 0 within the year.
   function automatic logic [8:0] month_start(input logic [3:0] month, input logic leap);
      logic [8:0] base;
      case (month)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd59;
         4'd3:    base = 9'd90;
         4'd4:    base = 9'd120;
         4'd5:    base = 9'd151;
         4'd6:    base = 9'd181;
         4'd7:    base = 9'd212;
         4'd8:    base = 9'd243;
         4'd9:    base = 9'd273;
         4'd10:   base = 9'd304;
         4'd11:   base = 9'd334;
         default: base = 9'd0;
      endcase
      if (leap && (month >= 4'd2)) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

endpackage

// ===== src/day_count_to_calendar_date.sv =====
// Calendar date converter: day count since 1978, minute of day and 1/50 s ticks in,
// year, month, day, hour, minute, second and an out-of-range flag out.
// Depends on dcd_pkg and day_count_to_calendar_date_defines.svh.
//
// The converter is a five-stage pipeline that takes one timestamp beat in every
// cycle in which req_stall is low. The whole pipeline advances together: while
// a finished result is held by rsp_stall, req_stall is raised and every stage
// keeps its contents. Stage one forms reciprocal products for the four-year
// cycle, hour and second quotients, stage two the remainders, stage three
// corrects the quotient estimates, stage four picks the year within the cycle,
// and stage five finds the month against the month start table. Every fourth
// year counted from 1976 is a leap year, with no century rule; out_of_range
// flags day counts past 31 December 2099.
`include "day_count_to_calendar_date_defines.svh"

module day_count_to_calendar_date
   import dcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_day_count,
   input  logic [10:0] req_minute_of_day,
   input  logic [11:0] req_tick_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month_index,
   output logic [4:0]  rsp_day_of_month,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second,
   output logic        rsp_out_of_range
);

   logic advance;

   // Stage 1: quotient estimates.
   logic        v1_ff;
   logic [16:0] days1_ff, days1_in;
   logic [5:0]  q1_ff, q1_in;
   logic [10:0] mod1_ff;
   logic [5:0]  h1_ff, h1_in;
   logic [11:0] tk1_ff;
   logic [6:0]  s1_ff, s1_in;
   logic        oor1_ff, oor1_in;
   logic [28:0] quad_prod;
   logic [19:0] hour_prod;
   logic [22:0] sec_prod;

   // Stage 2: remainders of the estimates.
   logic        v2_ff;
   logic [11:0] rem2_ff, rem2_in;
   logic [5:0]  q2_ff;
   logic [6:0]  hr2_ff, hr2_in;
   logic [5:0]  h2_ff;
   logic [6:0]  sr2_ff, sr2_in;
   logic [6:0]  s2_ff;
   logic        oor2_ff;

   // Stage 3: corrected quotients.
   logic        v3_ff;
   logic [10:0] rem3_ff, rem3_in;
   logic [5:0]  q3_ff, q3_in;
   logic [4:0]  h3_ff, h3_in;
   logic [5:0]  min3_ff, min3_in;
   logic [6:0]  stot3_ff, stot3_in;
   logic        oor3_ff;

   // Stage 4: year within the cycle.
   logic        v4_ff;
   logic [11:0] year4_ff, year4_in;
   logic [8:0]  doy4_ff, doy4_in;
   logic        leap4_ff, leap4_in;
   logic [4:0]  h4_ff;
   logic [5:0]  min4_ff;
   logic [5:0]  sec4_ff, sec4_in;
   logic        oor4_ff;

   // Stage 5: output register.
   logic        v5_ff;
   logic [11:0] year5_ff;
   logic [3:0]  month5_ff, month5_in;
   logic [4:0]  day5_ff, day5_in;
   logic [4:0]  h5_ff;
   logic [5:0]  min5_ff;
   logic [5:0]  sec5_ff;
   logic        oor5_ff;

   assign advance   = !(v5_ff && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      days1_in  = 17'(req_day_count) + 17'(DaysOffset);
      quad_prod = 29'(days1_in) * 29'(QuadRecip);
      q1_in     = 6'(quad_prod >> QuadShift);
      hour_prod = 20'(req_minute_of_day) * 20'(HourRecip);
      h1_in     = 6'(hour_prod >> HourShift);
      sec_prod  = 23'(req_tick_count) * 23'(SecRecip);
      s1_in     = 7'(sec_prod >> SecShift);
      oor1_in   = (req_day_count > 16'(LastDay2099));
   end

   always_comb begin
      rem2_in = 12'(days1_ff - 17'(q1_ff) * 17'(DaysPerQuad));
      hr2_in  = 7'(mod1_ff - 11'(h1_ff) * 11'(MinutesPerHour));
      sr2_in  = 7'(tk1_ff - 12'(s1_ff) * 12'(TicksPerSecond));
   end

   always_comb begin
      if (rem2_ff >= 12'(DaysPerQuad)) begin
         q3_in   = q2_ff + 6'd1;
         rem3_in = 11'(rem2_ff - 12'(DaysPerQuad));
      end else begin
         q3_in   = q2_ff;
         rem3_in = 11'(rem2_ff);
      end
      // The hour is kept to its five bits, so large minute counts wrap.
      if (hr2_ff >= 7'(MinutesPerHour)) begin
         h3_in   = 5'(h2_ff + 6'd1);
         min3_in = 6'(hr2_ff - 7'(MinutesPerHour));
      end else begin
         h3_in   = 5'(h2_ff);
         min3_in = 6'(hr2_ff);
      end
      if (sr2_ff >= 7'(TicksPerSecond)) begin
         stot3_in = s2_ff + 7'd1;
      end else begin
         stot3_in = s2_ff;
      end
   end

   always_comb begin
      logic [1:0]  yoff;
      logic [10:0] ystart;
      // The first year of each four-year cycle is the leap year.
      if (rem3_ff < 11'(DaysPerLeap)) begin
         yoff   = 2'd0;
         ystart = 11'd0;
      end else if (rem3_ff < 11'(DaysPerLeap + DaysPerYear)) begin
         yoff   = 2'd1;
         ystart = 11'(DaysPerLeap);
      end else if (rem3_ff < 11'(DaysPerLeap + 2 * DaysPerYear)) begin
         yoff   = 2'd2;
         ystart = 11'(DaysPerLeap + DaysPerYear);
      end else begin
         yoff   = 2'd3;
         ystart = 11'(DaysPerLeap + 2 * DaysPerYear);
      end
      leap4_in = (yoff == 2'd0);
      doy4_in  = 9'(rem3_ff - ystart);
      year4_in = 12'(BaseYear) + 12'({q3_ff, 2'b00}) + 12'(yoff);
      if (stot3_ff >= 7'(SecondsPerMin)) begin
         sec4_in = 6'(stot3_ff - 7'(SecondsPerMin));
      end else begin
         sec4_in = 6'(stot3_ff);
      end
   end

   always_comb begin
      month5_in = 4'd0;
      for (int i = 1; i < MonthCount; i++) begin
         if (doy4_ff >= month_start(4'(i), leap4_ff)) begin
            month5_in = month5_in + 4'd1;
         end
      end
      day5_in = 5'(doy4_ff - month_start(month5_in, leap4_ff) + 9'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         days1_ff  <= days1_in;
         q1_ff     <= q1_in;
         mod1_ff   <= req_minute_of_day;
         h1_ff     <= h1_in;
         tk1_ff    <= req_tick_count;
         s1_ff     <= s1_in;
         oor1_ff   <= oor1_in;

         rem2_ff   <= rem2_in;
         q2_ff     <= q1_ff;
         hr2_ff    <= hr2_in;
         h2_ff     <= h1_ff;
         sr2_ff    <= sr2_in;
         s2_ff     <= s1_ff;
         oor2_ff   <= oor1_ff;

         rem3_ff   <= rem3_in;
         q3_ff     <= q3_in;
         h3_ff     <= h3_in;
         min3_ff   <= min3_in;
         stot3_ff  <= stot3_in;
         oor3_ff   <= oor2_ff;

         year4_ff  <= year4_in;
         doy4_ff   <= doy4_in;
         leap4_ff  <= leap4_in;
         h4_ff     <= h3_ff;
         min4_ff   <= min3_ff;
         sec4_ff   <= sec4_in;
         oor4_ff   <= oor3_ff;

         year5_ff  <= year4_ff;
         month5_ff <= month5_in;
         day5_ff   <= day5_in;
         h5_ff     <= h4_ff;
         min5_ff   <= min4_ff;
         sec5_ff   <= sec4_ff;
         oor5_ff   <= oor4_ff;
      end
   end

   assign rsp_valid        = v5_ff;
   assign rsp_year         = year5_ff;
   assign rsp_month_index  = month5_ff;
   assign rsp_day_of_month = day5_ff;
   assign rsp_hour         = h5_ff;
   assign rsp_minute       = min5_ff;
   assign rsp_second       = sec5_ff;
   assign rsp_out_of_range = oor5_ff;

   `DCD_ASSERT_NEXT(a_held_result_stays, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `DCD_ASSERT_HOLDS(a_month_in_range, clock, reset, !rsp_valid || (rsp_month_index <= 4'd11))
   `DCD_ASSERT_HOLDS(a_day_nonzero, clock, reset, !rsp_valid || (rsp_day_of_month != 5'd0))
   `DCD_ASSERT_HOLDS(a_time_in_range, clock, reset,
      !rsp_valid || ((rsp_minute <= 6'd59) && (rsp_second <= 6'd59)))
   `DCD_ASSERT_HOLDS(a_flag_matches_year, clock, reset,
      !rsp_valid || (rsp_out_of_range == (rsp_year >= 12'd2100)))

endmodule
